// ===== hw/rtl/tf_pkg.sv =====
// Shared types, constants and functions for the Twofish block cipher unit.
// Holds the q permutations, the GF(2^8) multiply and the RS key-word reduction.
// No dependencies.
package tf_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [31:0] word_t;
	typedef logic [63:0] dword_t;

	// Feistel rounds per block
	localparam int ROUNDS = 16;
	localparam int RND_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

	// Subkeys live in pairs: entries 0..3 hold whitening keys, 4.. hold round keys
	localparam int KEY_PAIRS   = 20;
	localparam int KEY_AW      = $clog2(KEY_PAIRS);
	localparam int WHITE_PAIRS = 4;

	// Configuration register indexes
	localparam int CFG_IW = 3;
	localparam logic [CFG_IW-1:0] REG_KEY0 = 3'd0;
	localparam logic [CFG_IW-1:0] REG_KEY1 = 3'd1;
	localparam logic [CFG_IW-1:0] REG_KEY2 = 3'd2;
	localparam logic [CFG_IW-1:0] REG_KEY3 = 3'd3;
	localparam logic [CFG_IW-1:0] REG_KLEN = 3'd4;

	// Key length codes
	localparam logic [1:0] KLEN_128 = 2'd0;
	localparam logic [1:0] KLEN_192 = 2'd1;
	localparam logic [1:0] KLEN_256 = 2'd2;

	// Command codes
	localparam logic CMD_ENC = 1'b0;
	localparam logic CMD_DEC = 1'b1;

	// Field polynomials
	localparam logic [8:0] RS_POLY  = 9'h14D;
	localparam logic [8:0] MDS_POLY = 9'h169;

	// Nibble tables of q0 (first) and q1 (second), four tables each
	localparam logic [3:0] QTAB [2][4][16] = '{
		'{
			'{4'h8,4'h1,4'h7,4'hD,4'h6,4'hF,4'h3,4'h2,4'h0,4'hB,4'h5,4'h9,4'hE,4'hC,4'hA,4'h4},
			'{4'hE,4'hC,4'hB,4'h8,4'h1,4'h2,4'h3,4'h5,4'hF,4'h4,4'hA,4'h6,4'h7,4'h0,4'h9,4'hD},
			'{4'hB,4'hA,4'h5,4'hE,4'h6,4'hD,4'h9,4'h0,4'hC,4'h8,4'hF,4'h3,4'h2,4'h4,4'h7,4'h1},
			'{4'hD,4'h7,4'hF,4'h4,4'h1,4'h2,4'h6,4'hE,4'h9,4'hB,4'h3,4'h0,4'h8,4'h5,4'hC,4'hA}
		},
		'{
			'{4'h2,4'h8,4'hB,4'hD,4'hF,4'h7,4'h6,4'hE,4'h3,4'h1,4'h9,4'h4,4'h0,4'hA,4'hC,4'h5},
			'{4'h1,4'hE,4'h2,4'hB,4'h4,4'hC,4'h3,4'h7,4'h6,4'hD,4'hA,4'h5,4'hF,4'h9,4'h0,4'h8},
			'{4'h4,4'hC,4'h7,4'h5,4'h1,4'h6,4'h9,4'hA,4'h0,4'hE,4'hD,4'h8,4'h2,4'hB,4'h3,4'hF},
			'{4'hB,4'h9,4'h5,4'h1,4'hC,4'h3,4'hD,4'hE,4'h6,4'h4,4'h7,4'hF,4'h2,4'h0,4'h8,4'hA}
		}
	};

	localparam byte_t MDS_MAT [4][4] = '{
		'{8'h01, 8'hEF, 8'h5B, 8'h5B},
		'{8'h5B, 8'hEF, 8'hEF, 8'h01},
		'{8'hEF, 8'h5B, 8'h01, 8'hEF},
		'{8'hEF, 8'h01, 8'hEF, 8'h5B}
	};

	localparam byte_t RS_MAT [4][8] = '{
		'{8'h01, 8'hA4, 8'h55, 8'h87, 8'h5A, 8'h58, 8'hDB, 8'h9E},
		'{8'hA4, 8'h56, 8'h82, 8'hF3, 8'h1E, 8'hC6, 8'h68, 8'hE5},
		'{8'h02, 8'hA1, 8'hFC, 8'hC1, 8'h47, 8'hAE, 8'h3D, 8'h19},
		'{8'hA4, 8'h55, 8'h87, 8'h5A, 8'h58, 8'hDB, 8'h9E, 8'h03}
	};

	// q permutation built from its nibble tables; sel picks q0 or q1
	function automatic byte_t q_perm(input byte_t x, input logic sel);
		logic [3:0] a1, b1, a2, b2, a3, b3, a4, b4;
		a1 = x[7:4] ^ x[3:0];
		b1 = x[7:4] ^ {x[0], x[3:1]} ^ {x[4], 3'b000};
		a2 = QTAB[sel][0][a1];
		b2 = QTAB[sel][1][b1];
		a3 = a2 ^ b2;
		b3 = a2 ^ {b2[0], b2[3:1]} ^ {a2[0], 3'b000};
		a4 = QTAB[sel][2][a3];
		b4 = QTAB[sel][3][b3];
		return {b4, a4};
	endfunction

	// GF(2^8) multiply, reduced by the given polynomial
	function automatic byte_t gf_mul(input byte_t a, input byte_t b, input logic [8:0] poly);
		logic [8:0] p;
		byte_t r;
		p = {1'b0, a};
		r = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) r = r ^ p[7:0];
			p = {p[7:0], 1'b0};
			if (p[8]) p = p ^ poly;
		end
		return r;
	endfunction

	// RS reduction of eight key bytes into one S-box key word
	function automatic word_t rs_word(input dword_t k);
		word_t s;
		byte_t acc;
		s = '0;
		for (int row = 0; row < 4; row++) begin
			acc = '0;
			for (int j = 0; j < 8; j++) acc = acc ^ gf_mul(RS_MAT[row][j], k[8*j +: 8], RS_POLY);
			s[8*row +: 8] = acc;
		end
		return s;
	endfunction

endpackage

// ===== hw/rtl/tf_if.sv =====
// Handshake channels of the Twofish unit: block input, result output, config writes.
// Depends on tf_pkg for field widths.
interface tf_blk_if;
	logic             valid;
	logic             ready;
	logic             command;
	tf_pkg::dword_t   block_low;
	tf_pkg::dword_t   block_high;
	modport source (output valid, command, block_low, block_high, input ready);
	modport sink   (input valid, command, block_low, block_high, output ready);
endinterface

interface tf_res_if;
	logic             valid;
	logic             ready;
	tf_pkg::dword_t   result_low;
	tf_pkg::dword_t   result_high;
	modport source (output valid, result_low, result_high, input ready);
	modport sink   (input valid, result_low, result_high, output ready);
endinterface

interface tf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tf_pkg::CFG_IW-1:0]      index;
	tf_pkg::dword_t                 data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/twofish_block_cipher_unit.sv =====
// Top level of the Twofish block cipher unit: control sequencer, key schedule, round unit.
// Depends on tf_pkg, tf_if, tf_ram and tf_h.
//
// Usage:
//   blk carries one word per block: command (encrypt or decrypt) and the 128-bit block.
//   res returns one word per block with the transformed block.
//   cfg writes the key words and the key length code; write it only while idle.
//   Key word and length writes mark the key stale; the next block first expands the key.
// Sequence:
//   A block runs input whitening, S_RG and S_RF for each round, then output whitening.
//   Each round has an h step (S_RG) in the two h units and an update step (S_RF),
//   because the subkey pair memory has one read port with registered read data.
//   After a key change the first block is preceded by RS reduction (S_RS) and
//   subkey generation (S_KH then S_KW for each of the 20 subkey pairs).
//   A new block is taken no earlier than the cycle after the previous result is
//   loaded, so no block is taken while another is still being processed.
// Reset: the key reads as all zero with 128-bit length and is marked stale.
// Stall: the result sits in the output register until taken; the next block
//   may be accepted meanwhile and waits at its final step if that register is full.
module twofish_block_cipher_unit (
	input  logic       clk,
	input  logic       arst_n,
	tf_blk_if.sink     blk,
	tf_res_if.source   res,
	tf_cfg_if.sink     cfg
);
	import tf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_RS, S_KH, S_KW, S_WI0, S_WI1, S_WI2,
		S_RG, S_RF, S_WO0, S_WO1, S_WO2
	} state_t;

	localparam logic [KEY_AW-1:0] WK_LO_A  = KEY_AW'(0);
	localparam logic [KEY_AW-1:0] WK_LO_B  = KEY_AW'(1);
	localparam logic [KEY_AW-1:0] WK_HI_A  = KEY_AW'(2);
	localparam logic [KEY_AW-1:0] WK_HI_B  = KEY_AW'(3);
	localparam logic [KEY_AW-1:0] LAST_PR  = KEY_AW'(KEY_PAIRS - 1);
	localparam logic [KEY_AW-1:0] LAST_RND = KEY_AW'(ROUNDS - 1);

	state_t           state_q;
	logic [KEY_AW-1:0] cnt_q;
	logic             dec_q;
	logic             stale_q;
	logic [1:0]       klen_cfg_q;
	logic [1:0]       klen_q;
	dword_t           kw_q [4];
	logic [3:0][31:0] sbw_q;
	word_t            a_q, b_q, c_q, d_q;
	word_t            ha_q, hb_q;
	logic             out_valid_q;
	dword_t           out_lo_q, out_hi_q;

	// h unit inputs and results
	word_t            hx0, hx1, hy0, hy1;
	logic [3:0][31:0] hl0, hl1;
	logic [1:0]       hk;

	// subkey memory ports
	logic              ram_we, ram_re;
	logic [KEY_AW-1:0] ram_raddr;
	dword_t            ram_wdata, ram_rdata;

	// datapath helpers
	logic [2:0]        kwords, rs_tgt;
	logic [1:0]        rs_idx;
	logic              rs_used;
	word_t             rs_val;
	word_t             ks_a, ks_b, ks_s0, ks_s1;
	word_t             f0, f1, nc, nd;
	logic [KEY_AW-1:0] rnd;
	byte_t             ev_byte, od_byte;
	logic              out_load;

	assign cfg.ready  = 1'b1;
	assign blk.ready  = (state_q == S_IDLE);
	assign res.valid  = out_valid_q;
	assign res.result_low  = out_lo_q;
	assign res.result_high = out_hi_q;

	// load the output register from the final step once it is free
	assign out_load = (state_q == S_WO2) && (!out_valid_q || res.ready);

	// RS reduction: word i lands at k-1-i, unused words are cleared
	always_comb begin
		kwords  = (klen_cfg_q >= KLEN_256) ? 3'd4 : ({1'b0, klen_cfg_q} + 3'd2);
		rs_used = ({1'b0, cnt_q[1:0]} < kwords);
		rs_tgt  = rs_used ? (kwords - 3'd1 - {1'b0, cnt_q[1:0]}) : {1'b0, cnt_q[1:0]};
		rs_idx  = rs_tgt[1:0];
		rs_val  = rs_used ? rs_word(kw_q[cnt_q[1:0]]) : '0;
	end

	// select h unit operands: key schedule or round function
	always_comb begin
		ev_byte = {{(7 - KEY_AW){1'b0}}, cnt_q, 1'b0};
		od_byte = {{(7 - KEY_AW){1'b0}}, cnt_q, 1'b1};
		hx0 = a_q;
		hx1 = {b_q[23:0], b_q[31:24]};
		hl0 = sbw_q;
		hl1 = sbw_q;
		hk  = klen_q;
		if (state_q == S_KH) begin
			hx0 = {4{ev_byte}};
			hx1 = {4{od_byte}};
			hk  = klen_cfg_q;
			for (int i = 0; i < 4; i++) begin
				hl0[i] = kw_q[i][31:0];
				hl1[i] = kw_q[i][63:32];
			end
		end
	end

	tf_h u_h0 (.x(hx0), .l(hl0), .klen(hk), .y(hy0));
	tf_h u_h1 (.x(hx1), .l(hl1), .klen(hk), .y(hy1));

	// subkey pair from the two h results
	always_comb begin
		ks_a  = ha_q;
		ks_b  = {hb_q[23:0], hb_q[31:24]};
		ks_s0 = ks_a + ks_b;
		ks_s1 = ks_a + {ks_b[30:0], 1'b0};
		ram_wdata = {ks_s1[22:0], ks_s1[31:23], ks_s0};
		ram_we    = (state_q == S_KW);
	end

	// subkey memory read address per step
	always_comb begin
		rnd = (dec_q == CMD_DEC) ? (LAST_RND - cnt_q) : cnt_q;
		ram_re    = 1'b1;
		ram_raddr = rnd + KEY_AW'(WHITE_PAIRS);
		unique case (state_q)
			S_WI0:   ram_raddr = (dec_q == CMD_DEC) ? WK_HI_A : WK_LO_A;
			S_WI1:   ram_raddr = (dec_q == CMD_DEC) ? WK_HI_B : WK_LO_B;
			S_WO0:   ram_raddr = (dec_q == CMD_DEC) ? WK_LO_A : WK_HI_A;
			S_WO1:   ram_raddr = (dec_q == CMD_DEC) ? WK_LO_B : WK_HI_B;
			S_RG:    ram_raddr = rnd + KEY_AW'(WHITE_PAIRS);
			default: ram_re = 1'b0;
		endcase
	end

	tf_ram #(.DEPTH(KEY_PAIRS), .WIDTH(64)) u_subkeys (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// round update with the fetched subkey pair
	always_comb begin
		f0 = ha_q + hb_q + ram_rdata[31:0];
		f1 = ha_q + {hb_q[30:0], 1'b0} + ram_rdata[63:32];
		if (dec_q == CMD_DEC) begin
			nc = {c_q[30:0], c_q[31]} ^ f0;
			nd = d_q ^ f1;
			nd = {nd[0], nd[31:1]};
		end else begin
			nc = c_q ^ f0;
			nc = {nc[0], nc[31:1]};
			nd = {d_q[30:0], d_q[31]} ^ f1;
		end
	end

	// sequencer, config registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			dec_q       <= CMD_ENC;
			stale_q     <= 1'b1;
			klen_cfg_q  <= KLEN_128;
			klen_q      <= KLEN_128;
			for (int i = 0; i < 4; i++) kw_q[i] <= '0;
			sbw_q       <= '0;
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
			ha_q <= '0; hb_q <= '0;
			out_valid_q <= 1'b0;
			out_lo_q    <= '0;
			out_hi_q    <= '0;
		end else begin
			// raise on load, drop the result once taken
			if (out_load) out_valid_q <= 1'b1;
			else if (res.valid && res.ready) out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (blk.valid) begin
						dec_q <= blk.command;
						a_q   <= blk.block_low[31:0];
						b_q   <= blk.block_low[63:32];
						c_q   <= blk.block_high[31:0];
						d_q   <= blk.block_high[63:32];
						cnt_q <= '0;
						state_q <= stale_q ? S_RS : S_WI0;
					end
				end
				S_RS: begin
					sbw_q[rs_idx] <= rs_val;
					if (cnt_q[1:0] == 2'd3) begin
						cnt_q   <= '0;
						klen_q  <= klen_cfg_q;
						state_q <= S_KH;
					end else begin
						cnt_q <= cnt_q + KEY_AW'(1);
					end
				end
				S_KH: begin
					ha_q    <= hy0;
					hb_q    <= hy1;
					state_q <= S_KW;
				end
				S_KW: begin
					if (cnt_q == LAST_PR) begin
						cnt_q   <= '0;
						if (!cfg.valid) stale_q <= 1'b0;
						state_q <= S_WI0;
					end else begin
						cnt_q   <= cnt_q + KEY_AW'(1);
						state_q <= S_KH;
					end
				end
				S_WI0: state_q <= S_WI1;
				S_WI1: begin
					a_q <= a_q ^ ram_rdata[31:0];
					b_q <= b_q ^ ram_rdata[63:32];
					state_q <= S_WI2;
				end
				S_WI2: begin
					c_q <= c_q ^ ram_rdata[31:0];
					d_q <= d_q ^ ram_rdata[63:32];
					cnt_q   <= '0;
					state_q <= S_RG;
				end
				S_RG: begin
					ha_q    <= hy0;
					hb_q    <= hy1;
					state_q <= S_RF;
				end
				S_RF: begin
					if (cnt_q == LAST_RND) begin
						c_q <= nc;
						d_q <= nd;
						state_q <= S_WO0;
					end else begin
						a_q <= nc;
						b_q <= nd;
						c_q <= a_q;
						d_q <= b_q;
						cnt_q   <= cnt_q + KEY_AW'(1);
						state_q <= S_RG;
					end
				end
				S_WO0: state_q <= S_WO1;
				S_WO1: begin
					a_q <= a_q ^ ram_rdata[31:0];
					b_q <= b_q ^ ram_rdata[63:32];
					state_q <= S_WO2;
				end
				S_WO2: begin
					// hold until the output register is free
					if (out_load) begin
						out_lo_q    <= {b_q, a_q};
						out_hi_q    <= {d_q ^ ram_rdata[63:32], c_q ^ ram_rdata[31:0]};
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// config writes must arrive only while idle; the block itself does not enforce this
			if (cfg.valid) begin
				case (cfg.index)
					REG_KEY0: begin kw_q[0] <= cfg.data; stale_q <= 1'b1; end
					REG_KEY1: begin kw_q[1] <= cfg.data; stale_q <= 1'b1; end
					REG_KEY2: begin kw_q[2] <= cfg.data; stale_q <= 1'b1; end
					REG_KEY3: begin kw_q[3] <= cfg.data; stale_q <= 1'b1; end
					REG_KLEN: begin klen_cfg_q <= cfg.data[1:0]; stale_q <= 1'b1; end
					default: ;
				endcase
			end
		end
	end

	// a block taken with a stale key starts with key expansion
	a_stale_expand: assert property (@(posedge clk) disable iff (!arst_n)
		(blk.valid && blk.ready && stale_q) |=> (state_q == S_RS))
		else $error("stale key not expanded");

	// the last subkey pair write clears the stale mark
	a_stale_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_KW && cnt_q == LAST_PR && !cfg.valid) |=> !stale_q)
		else $error("stale mark left after expansion");

	// a result appears only from the final whitening step
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_WO2))
		else $error("result raised outside final step");
endmodule

// ===== hw/rtl/tf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tf_ram #(
	parameter int DEPTH = 20,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// read port, data held when idle
	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/tf_h.sv =====
// Keyed h function of Twofish: q-permutation layers mixed with key words, then MDS.
// Depends on tf_pkg.
module tf_h (
	input  tf_pkg::word_t        x,
	input  logic [3:0][31:0]     l,
	input  logic [1:0]           klen,
	output tf_pkg::word_t        y
);
	import tf_pkg::*;

	byte_t v [4];
	byte_t z [4];

	always_comb begin
		byte_t acc;
		v[0] = x[7:0];
		v[1] = x[15:8];
		v[2] = x[23:16];
		v[3] = x[31:24];
		// extra layer for 256-bit keys
		if (klen >= KLEN_256) begin
			v[0] = q_perm(v[0], 1'b1) ^ l[3][7:0];
			v[1] = q_perm(v[1], 1'b0) ^ l[3][15:8];
			v[2] = q_perm(v[2], 1'b0) ^ l[3][23:16];
			v[3] = q_perm(v[3], 1'b1) ^ l[3][31:24];
		end
		// extra layer for 192- and 256-bit keys
		if (klen >= KLEN_192) begin
			v[0] = q_perm(v[0], 1'b1) ^ l[2][7:0];
			v[1] = q_perm(v[1], 1'b1) ^ l[2][15:8];
			v[2] = q_perm(v[2], 1'b0) ^ l[2][23:16];
			v[3] = q_perm(v[3], 1'b0) ^ l[2][31:24];
		end
		z[0] = q_perm(q_perm(q_perm(v[0], 1'b0) ^ l[1][7:0], 1'b0) ^ l[0][7:0], 1'b1);
		z[1] = q_perm(q_perm(q_perm(v[1], 1'b1) ^ l[1][15:8], 1'b0) ^ l[0][15:8], 1'b0);
		z[2] = q_perm(q_perm(q_perm(v[2], 1'b0) ^ l[1][23:16], 1'b1) ^ l[0][23:16], 1'b1);
		z[3] = q_perm(q_perm(q_perm(v[3], 1'b1) ^ l[1][31:24], 1'b1) ^ l[0][31:24], 1'b0);
		// MDS multiply
		y = '0;
		for (int i = 0; i < 4; i++) begin
			acc = '0;
			for (int j = 0; j < 4; j++) acc = acc ^ gf_mul(MDS_MAT[i][j], z[j], MDS_POLY);
			y[8*i +: 8] = acc;
		end
	end
endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the Twofish block cipher unit: random and directed blocks, key changes.
// Depends on tf_pkg, tf_if and twofish_block_cipher_unit; predicts every result with its own cipher model.
module tb;
	import tf_pkg::*;

	typedef struct packed {
		logic   command;
		dword_t block_low;
		dword_t block_high;
	} blk_word_t;

	typedef struct packed {
		dword_t result_low;
		dword_t result_high;
	} res_word_t;

	logic clk;
	logic arst_n;

	tf_blk_if blk_ch ();
	tf_res_if res_ch ();
	tf_cfg_if cfg_ch ();

	twofish_block_cipher_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.blk    (blk_ch.sink),
		.res    (res_ch.source),
		.cfg    (cfg_ch.sink)
	);

	// cipher state kept by the predictor
	dword_t     key_reg [4];
	logic [1:0] klen_reg;
	logic       key_dirty;
	word_t      subkey [40];
	word_t      sbox_word [4];
	int         sbox_cnt;

	byte_t q0_tab [256];
	byte_t q1_tab [256];

	blk_word_t pending_blocks [$];
	res_word_t expected_results [$];

	int  errors;
	int  accepted;
	bit  idle_on;
	bit  hold_res;
	int  hold_cycles;
	bit  blk_taken;

	// lookup tables for the two q permutations, built from their definition
	function automatic byte_t q_calc(input byte_t x, input int sel);
		logic [3:0] t [2][4][16];
		logic [3:0] a0, b0, a1, b1, a2, b2, a3, b3, a4, b4;
		t[0][0] = '{8,1,7,13,6,15,3,2,0,11,5,9,14,12,10,4};
		t[0][1] = '{14,12,11,8,1,2,3,5,15,4,10,6,7,0,9,13};
		t[0][2] = '{11,10,5,14,6,13,9,0,12,8,15,3,2,4,7,1};
		t[0][3] = '{13,7,15,4,1,2,6,14,9,11,3,0,8,5,12,10};
		t[1][0] = '{2,8,11,13,15,7,6,14,3,1,9,4,0,10,12,5};
		t[1][1] = '{1,14,2,11,4,12,3,7,6,13,10,5,15,9,0,8};
		t[1][2] = '{4,12,7,5,1,6,9,10,0,14,13,8,2,11,3,15};
		t[1][3] = '{11,9,5,1,12,3,13,14,6,4,7,15,2,0,8,10};
		a0 = x[7:4];
		b0 = x[3:0];
		a1 = a0 ^ b0;
		b1 = a0 ^ {b0[0], b0[3:1]} ^ {a0[0], 3'b000};
		a2 = t[sel][0][a1];
		b2 = t[sel][1][b1];
		a3 = a2 ^ b2;
		b3 = a2 ^ {b2[0], b2[3:1]} ^ {a2[0], 3'b000};
		a4 = t[sel][2][a3];
		b4 = t[sel][3][b3];
		return {b4, a4};
	endfunction

	function automatic byte_t fmul(input byte_t a, input byte_t b, input logic [8:0] poly);
		logic [8:0] p;
		byte_t r;
		p = {1'b0, a};
		r = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) r = r ^ p[7:0];
			p = {p[7:0], 1'b0};
			if (p[8]) p = p ^ 9'h169 ^ 9'h169 ^ poly;
		end
		return r;
	endfunction

	function automatic word_t rol(input word_t x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// keyed h function followed by the MDS multiply
	function automatic word_t hmix(input word_t x, input word_t lw [4], input int k);
		byte_t y [4];
		byte_t m [4][4];
		byte_t acc;
		word_t r;
		m = '{'{8'h01, 8'hEF, 8'h5B, 8'h5B}, '{8'h5B, 8'hEF, 8'hEF, 8'h01},
		      '{8'hEF, 8'h5B, 8'h01, 8'hEF}, '{8'hEF, 8'h01, 8'hEF, 8'h5B}};
		for (int j = 0; j < 4; j++) y[j] = x[8*j +: 8];
		if (k == 4) begin
			y[0] = q1_tab[y[0]] ^ lw[3][7:0];
			y[1] = q0_tab[y[1]] ^ lw[3][15:8];
			y[2] = q0_tab[y[2]] ^ lw[3][23:16];
			y[3] = q1_tab[y[3]] ^ lw[3][31:24];
		end
		if (k >= 3) begin
			y[0] = q1_tab[y[0]] ^ lw[2][7:0];
			y[1] = q1_tab[y[1]] ^ lw[2][15:8];
			y[2] = q0_tab[y[2]] ^ lw[2][23:16];
			y[3] = q0_tab[y[3]] ^ lw[2][31:24];
		end
		y[0] = q1_tab[q0_tab[q0_tab[y[0]] ^ lw[1][7:0]] ^ lw[0][7:0]];
		y[1] = q0_tab[q0_tab[q1_tab[y[1]] ^ lw[1][15:8]] ^ lw[0][15:8]];
		y[2] = q1_tab[q1_tab[q0_tab[y[2]] ^ lw[1][23:16]] ^ lw[0][23:16]];
		y[3] = q0_tab[q1_tab[q1_tab[y[3]] ^ lw[1][31:24]] ^ lw[0][31:24]];
		r = '0;
		for (int i = 0; i < 4; i++) begin
			acc = 8'h00;
			for (int j = 0; j < 4; j++) acc = acc ^ fmul(m[i][j], y[j], 9'h169);
			r[8*i +: 8] = acc;
		end
		return r;
	endfunction

	// expand the held key into subkeys and S-box words
	task automatic schedule_key();
		byte_t rs [4][8];
		word_t even [4];
		word_t odd [4];
		word_t s, a, b;
		byte_t acc;
		int k;
		rs = '{'{8'h01, 8'hA4, 8'h55, 8'h87, 8'h5A, 8'h58, 8'hDB, 8'h9E},
		       '{8'hA4, 8'h56, 8'h82, 8'hF3, 8'h1E, 8'hC6, 8'h68, 8'hE5},
		       '{8'h02, 8'hA1, 8'hFC, 8'hC1, 8'h47, 8'hAE, 8'h3D, 8'h19},
		       '{8'hA4, 8'h55, 8'h87, 8'h5A, 8'h58, 8'hDB, 8'h9E, 8'h03}};
		k = (klen_reg >= 2) ? 4 : klen_reg + 2;
		for (int i = 0; i < 4; i++) begin
			even[i] = key_reg[i][31:0];
			odd[i] = key_reg[i][63:32];
			sbox_word[i] = '0;
		end
		for (int i = 0; i < k; i++) begin
			s = '0;
			for (int row = 0; row < 4; row++) begin
				acc = 8'h00;
				for (int j = 0; j < 8; j++)
					acc = acc ^ fmul(rs[row][j], key_reg[i][8*j +: 8], 9'h14D);
				s[8*row +: 8] = acc;
			end
			sbox_word[k-1-i] = s;
		end
		for (int i = 0; i < 20; i++) begin
			a = hmix(word_t'(2*i) * 32'h01010101, even, k);
			b = rol(hmix(word_t'(2*i+1) * 32'h01010101, odd, k), 8);
			subkey[2*i] = a + b;
			subkey[2*i+1] = rol(a + 2*b, 9);
		end
		sbox_cnt = k;
	endtask

	// encrypt or decrypt one block and queue its expected result
	task automatic predict_block(input blk_word_t w);
		word_t a, b, c, d, t0, t1, tmp;
		res_word_t r;
		if (key_dirty) begin
			schedule_key();
			key_dirty = 0;
		end
		a = w.block_low[31:0];
		b = w.block_low[63:32];
		c = w.block_high[31:0];
		d = w.block_high[63:32];
		if (w.command == CMD_ENC) begin
			a ^= subkey[0]; b ^= subkey[1]; c ^= subkey[2]; d ^= subkey[3];
			for (int rn = 0; rn < 16; rn++) begin
				t0 = hmix(a, sbox_word, sbox_cnt);
				t1 = hmix(rol(b, 8), sbox_word, sbox_cnt);
				c = rol(c ^ (t0 + t1 + subkey[2*rn+8]), 31);
				d = rol(d, 1) ^ (t0 + 2*t1 + subkey[2*rn+9]);
				if (rn != 15) begin
					tmp = a; a = c; c = tmp;
					tmp = b; b = d; d = tmp;
				end
			end
			a ^= subkey[4]; b ^= subkey[5]; c ^= subkey[6]; d ^= subkey[7];
		end else begin
			a ^= subkey[4]; b ^= subkey[5]; c ^= subkey[6]; d ^= subkey[7];
			for (int rn = 15; rn >= 0; rn--) begin
				if (rn != 15) begin
					tmp = a; a = c; c = tmp;
					tmp = b; b = d; d = tmp;
				end
				t0 = hmix(a, sbox_word, sbox_cnt);
				t1 = hmix(rol(b, 8), sbox_word, sbox_cnt);
				c = rol(c, 1) ^ (t0 + t1 + subkey[2*rn+8]);
				d = rol(d ^ (t0 + 2*t1 + subkey[2*rn+9]), 31);
			end
			a ^= subkey[0]; b ^= subkey[1]; c ^= subkey[2]; d ^= subkey[3];
		end
		r.result_low = {b, a};
		r.result_high = {d, c};
		expected_results.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input dword_t got, input dword_t want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit idle_roll();
		return idle_on && ($urandom_range(99) < 29);
	endfunction

	// driver: present pending words on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!blk_ch.valid || blk_taken) begin
				if (pending_blocks.size() != 0 && !idle_roll()) begin
					blk_ch.valid <= 1'b1;
					{blk_ch.command, blk_ch.block_low, blk_ch.block_high} <=
						pending_blocks.pop_front();
				end else begin
					blk_ch.valid <= 1'b0;
				end
			end
			res_ch.ready <= !hold_res && !idle_roll();
		end
	end

	// hold-off counter for the receiver
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			if (hold_cycles == 1) hold_res <= 0;
		end
	end

	// predict on block accept, compare on result accept
	always @(posedge clk) begin
		blk_taken <= arst_n && blk_ch.valid && blk_ch.ready;
		if (arst_n && blk_ch.valid && blk_ch.ready) begin
			predict_block({blk_ch.command, blk_ch.block_low, blk_ch.block_high});
			accepted++;
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result_low", res_ch.result_low, '0);
			end else begin
				res_word_t e;
				e = expected_results.pop_front();
				if (res_ch.result_low !== e.result_low)
					report_mismatch("result_low", res_ch.result_low, e.result_low);
				if (res_ch.result_high !== e.result_high)
					report_mismatch("result_high", res_ch.result_high, e.result_high);
			end
		end
	end

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input dword_t val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
				key_reg[idx] = val;
				key_dirty = 1;
			end
			REG_KLEN: begin
				klen_reg = val[1:0];
				key_dirty = 1;
			end
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic dword_t rnd64();
		return {$urandom, $urandom};
	endfunction

	// wait until every queued block has come back, then let the unit settle
	task automatic drain();
		while (pending_blocks.size() != 0 || blk_ch.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic new_key(input logic [1:0] klen, input int style);
		for (int i = 0; i < 4; i++) begin
			case (style)
				0: write_reg(CFG_IW'(i), '0);
				1: write_reg(CFG_IW'(i), '1);
				default: write_reg(CFG_IW'(i), rnd64());
			endcase
		end
		write_reg(REG_KLEN, {62'd0, klen});
	endtask

	task automatic push_block(input logic cmd, input dword_t lo, input dword_t hi);
		blk_word_t w;
		w.command = cmd;
		w.block_low = lo;
		w.block_high = hi;
		pending_blocks.push_back(w);
	endtask

	initial begin
		blk_word_t w;
		for (int i = 0; i < 256; i++) begin
			q0_tab[i] = q_calc(byte_t'(i), 0);
			q1_tab[i] = q_calc(byte_t'(i), 1);
		end
		errors = 0;
		accepted = 0;
		idle_on = 1;
		hold_res = 0;
		hold_cycles = 0;
		for (int i = 0; i < 4; i++) key_reg[i] = '0;
		klen_reg = KLEN_128;
		key_dirty = 1;
		clk = 1'b0;
		arst_n = 1'b0;
		blk_ch.valid = 1'b0;
		blk_ch.command = CMD_ENC;
		blk_ch.block_low = '0;
		blk_ch.block_high = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset key, extremes of the block, both commands
		push_block(CMD_ENC, '0, '0);
		push_block(CMD_DEC, '0, '0);
		push_block(CMD_ENC, '1, '1);
		push_block(CMD_DEC, '1, '1);
		push_block(CMD_ENC, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
		drain();
		// all-ones keys at each length, and length code three
		for (int l = 0; l < 4; l++) begin
			new_key(2'(l), 1);
			push_block(CMD_ENC, '0, '1);
			push_block(CMD_DEC, '1, '0);
			drain();
		end
		// rewrite the key length code with KLEN_256, then out-of-range indexes
		write_reg(REG_KLEN, {62'd0, KLEN_256});
		write_reg(3'd5, rnd64());
		write_reg(3'd7, rnd64());
		push_block(CMD_ENC, rnd64(), rnd64());
		drain();

		// random phases over key lengths
		for (int ph = 0; ph < 12; ph++) begin
			new_key(2'($urandom_range(3)), (ph == 0) ? 0 : 2);
			idle_on = (ph != 3);
			if (ph == 5) begin
				hold_res = 1;
				hold_cycles = 400;
			end
			for (int n = 0; n < 135; n++)
				push_block(1'($urandom), rnd64(), rnd64());
			drain();
		end

		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#40000000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule

// ===== twofish_block_cipher_unit.f =====
hw/rtl/tf_pkg.sv
hw/rtl/tf_if.sv
hw/rtl/tf_ram.sv
hw/rtl/tf_h.sv
hw/rtl/twofish_block_cipher_unit.sv
tb/sv/tb.sv
